[src/awdg_pkg.sv]
`timescale 1ns / 1ps
// Shared types, codes and constants of the armed waveform disturbance generator.
// Holds the sine table, which is built at elaboration. Depends on nothing.
package awdg_pkg;

    localparam int SINE_TABLE_DEPTH = 256;
    localparam int SINE_IDX_W       = $clog2(SINE_TABLE_DEPTH);
    localparam int CHANNEL_COUNT    = 14;
    localparam int CFG_INDEX_W      = 3;
    localparam int CFG_DATA_W       = 32;

    localparam logic [11:0] TRIG_HIGH = 12'd900;
    localparam logic [11:0] TRIG_LOW  = 12'd100;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_ARM  = 1'b1;

    localparam logic [1:0] DIR_UP   = 2'b01;
    localparam logic [1:0] DIR_DOWN = 2'b11;

    localparam logic [2:0] WAVE_OFFSET = 3'd0;
    localparam logic [2:0] WAVE_SQUARE = 3'd1;
    localparam logic [2:0] WAVE_RAMP   = 3'd2;
    localparam logic [2:0] WAVE_SINE   = 3'd3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_WAVE_TYPE,
        REG_PHASE_STEP,
        REG_AMPLITUDE,
        REG_OFFSET,
        REG_RUN_LENGTH,
        REG_ARM_TIMEOUT,
        REG_SWITCH_DIR,
        REG_DRIVE_TYPE
    } reg_index_t;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_WAIT,
        MODE_RUN
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WAITING,
        ST_RUNNING,
        ST_TIMED_OUT,
        ST_REFUSED
    } status_t;

    typedef struct packed {
        logic [2:0]         wave_type;
        logic [31:0]        phase_step;
        logic signed [15:0] amplitude;
        logic signed [15:0] offset;
        logic [23:0]        run_length;
        logic [23:0]        arm_timeout;
        logic [1:0]         switch_dir;
        logic [1:0]         drive_type;
    } cfg_t;

    typedef struct packed {
        logic        active;
        logic [3:0]  channel;
        logic        finished;
        status_t     status;
        logic [31:0] phase;
    } drive_t;

    typedef logic signed [15:0] sine_table_t [SINE_TABLE_DEPTH];

    function automatic sine_table_t build_sine_table();
        sine_table_t tbl;
        longint      p;
        longint      f;
        longint      z;
        longint      z2;
        longint      t;
        longint      q;
        for (int i = 0; i < SINE_TABLE_DEPTH; i++)
        begin
            p  = (longint'(i) <<< 18) / SINE_TABLE_DEPTH;
            q  = (p >>> 16) & 64'sd3;
            f  = p & 64'sd65535;
            z  = q[0] ? (64'sd65536 - f) : f;
            z2 = (z * z) >>> 16;
            t  = (64'sd5223 * z2) >>> 16;
            t  = 64'sd42334 - t;
            t  = (t * z2) >>> 16;
            t  = 64'sd102944 - t;
            t  = (z * t) >>> 16;
            t  = (t + 64'sd2) >>> 2;
            if (t > 64'sd16384)
            begin
                t = 64'sd16384;
            end
            tbl[i] = q[1] ? 16'(-t) : 16'(t);
        end
        return tbl;
    endfunction

    localparam sine_table_t SINE_TABLE = build_sine_table();

endpackage

[src/awdg_if.sv]
`timescale 1ns / 1ps
// Handshake channels: input items, result items and configuration writes.
// Depends on awdg_pkg.
interface awdg_item_if
    import awdg_pkg::*;
();
    logic        valid;
    logic        ready;
    logic        operation;
    logic [3:0]  channel;
    logic [11:0] switch_sample;

    modport source (output valid, operation, channel, switch_sample, input ready);
    modport sink (input valid, operation, channel, switch_sample, output ready);
endinterface

interface awdg_result_if
    import awdg_pkg::*;
();
    logic        valid;
    logic        ready;
    logic        active;
    logic [3:0]  out_channel;
    logic [1:0]  out_type;
    logic signed [15:0] wave_value;
    logic        finished;
    logic [2:0]  status;

    modport source (output valid, active, out_channel, out_type, wave_value, finished,
                    status, input ready);
    modport sink (input valid, active, out_channel, out_type, wave_value, finished,
                  status, output ready);
endinterface

interface awdg_cfg_if
    import awdg_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[src/awdg_cfg_regs.sv]
`timescale 1ns / 1ps
// Configuration register file, written through the configuration channel.
// Depends on awdg_pkg and awdg_cfg_if.
module awdg_cfg_regs
    import awdg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    awdg_cfg_if.sink    cfg,
    output cfg_t        regs
);

    cfg_t regs_reg;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.wave_type   <= WAVE_OFFSET;
            regs_reg.phase_step  <= 32'd42949673;
            regs_reg.amplitude   <= '0;
            regs_reg.offset      <= '0;
            regs_reg.run_length  <= 24'd256;
            regs_reg.arm_timeout <= 24'd1000;
            regs_reg.switch_dir  <= 2'b00;
            regs_reg.drive_type  <= 2'd2;
        end
        else if (cfg.valid)
        begin
            unique case (reg_index_t'(cfg.index))
                REG_WAVE_TYPE:   regs_reg.wave_type   <= cfg.data[2:0];
                REG_PHASE_STEP:  regs_reg.phase_step  <= cfg.data[31:0];
                REG_AMPLITUDE:   regs_reg.amplitude   <= cfg.data[15:0];
                REG_OFFSET:      regs_reg.offset      <= cfg.data[15:0];
                REG_RUN_LENGTH:  regs_reg.run_length  <= cfg.data[23:0];
                REG_ARM_TIMEOUT: regs_reg.arm_timeout <= cfg.data[23:0];
                REG_SWITCH_DIR:  regs_reg.switch_dir  <= cfg.data[1:0];
                REG_DRIVE_TYPE:  regs_reg.drive_type  <= cfg.data[1:0];
            endcase
        end
    end

endmodule

[src/awdg_ctrl.sv]
`timescale 1ns / 1ps
// Arm, wait and run sequencer with the phase accumulator and period counter.
// Registers one drive record per accepted item. Depends on awdg_pkg.
module awdg_ctrl
    import awdg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        regs,
    input  logic        accept,
    input  logic        advance,
    input  logic        operation,
    input  logic [3:0]  channel,
    input  logic [11:0] switch_sample,
    output logic        stage_valid,
    output drive_t      stage
);

    mode_t       mode_reg, mode_next;
    logic [3:0]  chan_reg, chan_next;
    logic [31:0] phase_reg, phase_next;
    logic [15:0] count_reg, count_next;
    logic [23:0] wait_reg, wait_next;
    logic        stage_valid_reg;
    drive_t      stage_reg, stage_next;

    logic        refused;
    logic        trig;
    logic        carry;
    logic [31:0] phase_sum;
    logic [15:0] count_inc;
    logic [23:0] wait_inc;
    logic        timeout;
    logic [31:0] drv_phase;
    logic [15:0] drv_count;
    logic        fin;

    assign refused = !((regs.switch_dir == DIR_UP) || (regs.switch_dir == DIR_DOWN))
                     || ({1'b0, channel} >= 5'(CHANNEL_COUNT));
    assign trig = ((regs.switch_dir == DIR_DOWN) && (switch_sample > TRIG_HIGH))
                  || ((regs.switch_dir == DIR_UP) && (switch_sample < TRIG_LOW));
    assign {carry, phase_sum} = {1'b0, phase_reg} + {1'b0, regs.phase_step};
    assign count_inc = (carry && (count_reg != '1)) ? count_reg + 16'd1 : count_reg;
    assign wait_inc  = wait_reg + 24'd1;
    assign timeout   = wait_inc >= regs.arm_timeout;
    assign drv_phase = (mode_reg == MODE_RUN) ? phase_sum : '0;
    assign drv_count = (mode_reg == MODE_RUN) ? count_inc : '0;
    assign fin       = {drv_count, drv_phase} >= {regs.run_length, 24'd0};

    always_comb
    begin
        mode_next = mode_reg;
        if (accept)
        begin
            if (operation == OP_ARM)
            begin
                mode_next = refused ? MODE_IDLE : MODE_WAIT;
            end
            else
            begin
                unique case (mode_reg)
                    MODE_WAIT:
                    begin
                        if (trig)
                        begin
                            mode_next = fin ? MODE_IDLE : MODE_RUN;
                        end
                        else if (timeout)
                        begin
                            mode_next = MODE_IDLE;
                        end
                    end
                    MODE_RUN:  mode_next = fin ? MODE_IDLE : MODE_RUN;
                    default:   mode_next = MODE_IDLE;
                endcase
            end
        end
    end

    always_comb
    begin
        chan_next  = chan_reg;
        phase_next = phase_reg;
        count_next = count_reg;
        wait_next  = wait_reg;
        stage_next = '{active: 1'b0, channel: 4'd0, finished: 1'b0,
                       status: ST_IDLE, phase: 32'd0};
        if (accept)
        begin
            if (operation == OP_ARM)
            begin
                if (refused)
                begin
                    stage_next.status = ST_REFUSED;
                end
                else
                begin
                    chan_next         = channel;
                    wait_next         = '0;
                    phase_next        = '0;
                    count_next        = '0;
                    stage_next.status = ST_WAITING;
                end
            end
            else
            begin
                unique case (mode_reg)
                    MODE_WAIT:
                    begin
                        if (trig)
                        begin
                            phase_next          = '0;
                            count_next          = '0;
                            stage_next.active   = 1'b1;
                            stage_next.channel  = chan_reg;
                            stage_next.finished = fin;
                            stage_next.status   = ST_RUNNING;
                        end
                        else
                        begin
                            wait_next         = wait_inc;
                            stage_next.status = timeout ? ST_TIMED_OUT : ST_WAITING;
                        end
                    end
                    MODE_RUN:
                    begin
                        phase_next          = phase_sum;
                        count_next          = count_inc;
                        stage_next.active   = 1'b1;
                        stage_next.channel  = chan_reg;
                        stage_next.finished = fin;
                        stage_next.status   = ST_RUNNING;
                        stage_next.phase    = drv_phase;
                    end
                    default:
                    begin
                        stage_next.status = ST_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_IDLE;
            chan_reg        <= '0;
            phase_reg       <= '0;
            count_reg       <= '0;
            wait_reg        <= '0;
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg  <= mode_next;
            chan_reg  <= chan_next;
            phase_reg <= phase_next;
            count_reg <= count_next;
            wait_reg  <= wait_next;
            if (advance)
            begin
                stage_valid_reg <= accept;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            stage_reg <= stage_next;
        end
    end

    assign stage_valid = stage_valid_reg;
    assign stage       = stage_reg;

endmodule

[src/awdg_wave.sv]
`timescale 1ns / 1ps
// Wave shaper: offset, or square/ramp/sine times amplitude plus offset, saturated.
// Holds the result register. Depends on awdg_pkg and awdg_result_if.
module awdg_wave
    import awdg_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  cfg_t          regs,
    input  logic          stage_valid,
    input  drive_t        stage,
    output logic          stall,
    awdg_result_if.source result
);

    logic               valid_reg;
    logic               active_reg;
    logic [3:0]         channel_reg;
    logic [1:0]         type_reg;
    logic signed [15:0] value_reg;
    logic               finished_reg;
    logic [2:0]         status_reg;

    logic signed [15:0] sine_val;
    logic signed [16:0] mul_b;
    logic signed [32:0] prod;
    logic signed [18:0] scaled;
    logic signed [18:0] off_ext;
    logic signed [18:0] amp_ext;
    logic signed [18:0] sum;
    logic signed [15:0] sat_val;

    assign sine_val = SINE_TABLE[stage.phase[31 -: SINE_IDX_W]];
    assign mul_b    = (regs.wave_type == WAVE_RAMP) ? $signed({1'b0, stage.phase[31:16]})
                                                    : $signed({sine_val[15], sine_val});
    assign prod     = regs.amplitude * mul_b;
    assign scaled   = (regs.wave_type == WAVE_RAMP) ? {{2{prod[32]}}, prod[32:16]}
                                                    : prod[32:14];
    assign off_ext  = {{3{regs.offset[15]}}, regs.offset};
    assign amp_ext  = {{3{regs.amplitude[15]}}, regs.amplitude};

    always_comb
    begin
        unique case (regs.wave_type)
            WAVE_OFFSET: sum = off_ext;
            WAVE_SQUARE: sum = stage.phase[31] ? amp_ext + off_ext : off_ext;
            WAVE_RAMP:   sum = scaled + off_ext;
            WAVE_SINE:   sum = scaled + off_ext;
            default:     sum = '0;
        endcase
    end

    always_comb
    begin
        if ((sum[18:15] == 4'b0000) || (sum[18:15] == 4'b1111))
        begin
            sat_val = sum[15:0];
        end
        else
        begin
            sat_val = sum[18] ? 16'sh8000 : 16'sh7FFF;
        end
    end

    assign stall = valid_reg && !result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!stall)
        begin
            valid_reg <= stage_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!stall)
        begin
            active_reg   <= stage.active;
            channel_reg  <= stage.channel;
            type_reg     <= stage.active ? regs.drive_type : 2'd0;
            value_reg    <= stage.active ? sat_val : 16'sd0;
            finished_reg <= stage.finished;
            status_reg   <= stage.status;
        end
    end

    assign result.valid       = valid_reg;
    assign result.active      = active_reg;
    assign result.out_channel = channel_reg;
    assign result.out_type    = type_reg;
    assign result.wave_value  = value_reg;
    assign result.finished    = finished_reg;
    assign result.status      = status_reg;

endmodule

[src/armed_waveform_disturbance_generator.sv]
`timescale 1ns / 1ps
// Top level of the armed waveform disturbance generator.
// Depends on awdg_pkg, the channel interfaces, awdg_cfg_regs, awdg_ctrl, awdg_wave.
//
//  Channel   Direction  Handshake     Carries
//  item      in         valid/ready   operation, channel, switch_sample
//  result    out        valid/ready   active, out_channel, out_type, wave_value,
//                                     finished, status
//  cfg       in         valid/ready   index, data (ready always high)
//
// One item per cycle unless the result register stalls; each item gives one result.
// The sequencer stage updates state and phase; the wave stage does table, multiply
// and saturation, then the result register.
// Reset: asynchronous, active low; loads register defaults, mode idle, no valid item.
// A stalled result register holds the whole pipe and drops item.ready.
module armed_waveform_disturbance_generator
    import awdg_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    awdg_item_if.sink     item,
    awdg_result_if.source result,
    awdg_cfg_if.sink      cfg
);

    cfg_t   regs;
    logic   stall;
    logic   advance;
    logic   accept;
    logic   stage_valid;
    drive_t stage;

    assign advance    = !stall;
    assign item.ready = advance;
    assign accept     = item.valid && advance;

    awdg_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    awdg_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .regs          (regs),
        .accept        (accept),
        .advance       (advance),
        .operation     (item.operation),
        .channel       (item.channel),
        .switch_sample (item.switch_sample),
        .stage_valid   (stage_valid),
        .stage         (stage)
    );

    awdg_wave u_wave (
        .clk         (clk),
        .rst_n       (rst_n),
        .regs        (regs),
        .stage_valid (stage_valid),
        .stage       (stage),
        .stall       (stall),
        .result      (result)
    );

endmodule

[src/awdg_checker.sv]
`timescale 1ns / 1ps
// Port-level checks of the disturbance generator, bound to its top level.
// Depends on awdg_pkg and armed_waveform_disturbance_generator.
module awdg_checker
    import awdg_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        active,
    input logic [3:0]  out_channel,
    input logic [1:0]  out_type,
    input logic [15:0] wave_value,
    input logic        finished,
    input logic [2:0]  status
);

    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !active |->
            out_channel == 4'd0 && out_type == 2'd0 && wave_value == 16'd0 && !finished)
        else $error("inactive result carries nonzero fields");

    a_active_running: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (active == (status == ST_RUNNING)))
        else $error("active disagrees with running status");

    a_channel_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && active |-> {1'b0, out_channel} < 5'(CHANNEL_COUNT))
        else $error("driven channel out of range");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(wave_value) && $stable(status))
        else $error("stalled result changed");

endmodule

bind armed_waveform_disturbance_generator awdg_checker u_awdg_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .active      (result.active),
    .out_channel (result.out_channel),
    .out_type    (result.out_type),
    .wave_value  (result.wave_value),
    .finished    (result.finished),
    .status      (result.status)
);
